FILE: src/ocx_pkg.sv
package ocx_pkg;

  // fixed field widths
  localparam int unsigned GENE_W  = 7;
  localparam int unsigned CUT_W   = 6;
  localparam int unsigned COUNT_W = 7;

  localparam logic [COUNT_W-1:0] CLIENT_COUNT_RST = 7'd64;

  // one queued item as classified by the front end
  typedef struct packed {
    logic              store;  // load slot still free, write the pair
    logic              last;   // final pair, starts a run
    logic [GENE_W-1:0] gene1;
    logic [GENE_W-1:0] gene2;
  } ocx_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_COPY = 4'b0010,
    ST_FILL = 4'b0100,
    ST_OUT  = 4'b1000
  } ocx_state_e;

endpackage

FILE: src/ocx_front.sv
module ocx_front #(
  parameter int unsigned MAX_GENES = 64,
  parameter int unsigned IDX_W     = $clog2(MAX_GENES),
  parameter int unsigned CNT_W     = $clog2(MAX_GENES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [CNT_W-1:0]            n_i,
  input  logic                        accept_i,
  input  logic [ocx_pkg::GENE_W-1:0]  parent1_gene_i,
  input  logic [ocx_pkg::GENE_W-1:0]  parent2_gene_i,
  input  logic [ocx_pkg::CUT_W-1:0]   cut_start_i,
  input  logic [ocx_pkg::CUT_W-1:0]   cut_end_i,
  input  logic                        last_pair_i,
  output ocx_pkg::ocx_cmd_t           cmd_o,
  output logic [IDX_W-1:0]            widx_o,
  output logic [IDX_W-1:0]            cs_o,
  output logic [IDX_W-1:0]            ce_o
);

  logic [CNT_W-1:0] load_q, load_d;
  logic             store;
  logic [CNT_W-1:0] n_m1;

  assign store = (load_q < CNT_W'(MAX_GENES));
  assign n_m1  = n_i - CNT_W'(1);

  assign cmd_o.store = store;
  assign cmd_o.last  = last_pair_i;
  assign cmd_o.gene1 = parent1_gene_i;
  assign cmd_o.gene2 = parent2_gene_i;
  assign widx_o      = load_q[IDX_W-1:0];

  // cut points at or past the count clamp to the last position
  always_comb begin
    if ({1'b0, cut_start_i} >= ocx_pkg::GENE_W'(n_i)) begin
      cs_o = n_m1[IDX_W-1:0];
    end else begin
      cs_o = cut_start_i[IDX_W-1:0];
    end
    if ({1'b0, cut_end_i} >= ocx_pkg::GENE_W'(n_i)) begin
      ce_o = n_m1[IDX_W-1:0];
    end else begin
      ce_o = cut_end_i[IDX_W-1:0];
    end
  end

  always_comb begin
    load_d = load_q;
    if (accept_i) begin
      if (last_pair_i) begin
        load_d = '0;
      end else if (store) begin
        load_d = load_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
    end else begin
      load_q <= load_d;
    end
  end

endmodule

FILE: src/ocx_queue.sv
module ocx_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o,
  output logic              full_o
);

  logic [DATA_W-1:0] slot_q [2];
  logic              wptr_q, rptr_q;
  logic [1:0]        cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: src/ocx_back.sv
module ocx_back #(
  parameter int unsigned MAX_GENES = 64,
  parameter int unsigned IDX_W     = $clog2(MAX_GENES),
  parameter int unsigned CNT_W     = $clog2(MAX_GENES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [CNT_W-1:0]            n_i,
  input  logic                        avail_i,
  output logic                        pop_o,
  input  ocx_pkg::ocx_cmd_t           cmd_i,
  input  logic [IDX_W-1:0]            widx_i,
  input  logic [IDX_W-1:0]            cs_i,
  input  logic [IDX_W-1:0]            ce_i,
  output logic                        strobe_o,
  output logic [ocx_pkg::GENE_W-1:0]  gene_o,
  output logic                        last_o
);

  localparam int unsigned GW = ocx_pkg::GENE_W;

  logic [GW-1:0] p1_mem [MAX_GENES];
  logic [GW-1:0] p2_mem [MAX_GENES];
  logic [GW-1:0] ch_mem [MAX_GENES];
  logic [GW-1:0] p1_rd_q, p2_rd_q, ch_rd_q;

  ocx_pkg::ocx_state_e state_q;
  logic [CNT_W-1:0]    cnt_q, copied_q, remain_q;
  logic [IDX_W-1:0]    pos_q, fr_q, cw_pos_q;
  logic [MAX_GENES:0]  used_q;
  logic [MAX_GENES-1:0] filled_q;
  logic                cp_v_q, fv_q, ov_q, olast_q, owr_q;

  logic [IDX_W-1:0] pos_nx, fr_nx, ce_nx;
  logic [CNT_W:0]   diff, diff_m;
  logic [CNT_W-1:0] copied_new;
  logic             p2_used, fill_we, start;
  logic             ch_we;
  logic [IDX_W-1:0] ch_wa;
  logic [GW-1:0]    ch_wd;

  assign pop_o = avail_i && (state_q == ocx_pkg::ST_IDLE);
  assign start = pop_o && cmd_i.last;

  // ring steps modulo the active count
  assign pos_nx = (CNT_W'(pos_q) + CNT_W'(1) == n_i) ? '0 : pos_q + IDX_W'(1);
  assign fr_nx  = (CNT_W'(fr_q) + CNT_W'(1) == n_i) ? '0 : fr_q + IDX_W'(1);
  assign ce_nx  = (CNT_W'(ce_i) + CNT_W'(1) == n_i) ? '0 : ce_i + IDX_W'(1);

  // copied = ((ce + n - cs) mod n) + 1; the sum stays below 2n
  assign diff       = (CNT_W+1)'(ce_i) + (CNT_W+1)'(n_i) - (CNT_W+1)'(cs_i);
  assign diff_m     = (diff >= (CNT_W+1)'(n_i)) ? diff - (CNT_W+1)'(n_i) : diff;
  assign copied_new = diff_m[CNT_W-1:0] + CNT_W'(1);

  // ids above the map range never count as used
  assign p2_used = (p2_rd_q <= GW'(MAX_GENES)) && used_q[p2_rd_q[CNT_W-1:0]];
  assign fill_we = fv_q && !p2_used && (remain_q != '0);

  always_comb begin
    ch_we = 1'b0;
    ch_wa = pos_q;
    ch_wd = p2_rd_q;
    if (cp_v_q) begin
      ch_we = 1'b1;
      ch_wa = cw_pos_q;
      ch_wd = p1_rd_q;
    end else if (fill_we) begin
      ch_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ocx_pkg::ST_IDLE;
      cnt_q    <= '0;
      copied_q <= '0;
      remain_q <= '0;
      pos_q    <= '0;
      fr_q     <= '0;
      cw_pos_q <= '0;
      used_q   <= '0;
      filled_q <= '0;
      cp_v_q   <= 1'b0;
      fv_q     <= 1'b0;
      ov_q     <= 1'b0;
      olast_q  <= 1'b0;
      owr_q    <= 1'b0;
    end else begin
      cp_v_q <= 1'b0;
      fv_q   <= 1'b0;
      ov_q   <= 1'b0;
      case (state_q)
        ocx_pkg::ST_IDLE: begin
          if (start) begin
            state_q  <= ocx_pkg::ST_COPY;
            cnt_q    <= '0;
            pos_q    <= cs_i;
            fr_q     <= ce_nx;
            copied_q <= copied_new;
            remain_q <= n_i - copied_new;
            used_q   <= '0;
            filled_q <= '0;
          end
        end
        ocx_pkg::ST_COPY: begin
          cp_v_q   <= 1'b1;
          cw_pos_q <= pos_q;
          pos_q    <= pos_nx;
          cnt_q    <= cnt_q + CNT_W'(1);
          if (cnt_q + CNT_W'(1) == copied_q) begin
            state_q <= ocx_pkg::ST_FILL;
            cnt_q   <= '0;
          end
        end
        ocx_pkg::ST_FILL: begin
          // n reads of parent two, then a final step for the last check
          if (cnt_q != n_i) begin
            fv_q  <= 1'b1;
            fr_q  <= fr_nx;
            cnt_q <= cnt_q + CNT_W'(1);
          end else begin
            state_q <= ocx_pkg::ST_OUT;
            cnt_q   <= '0;
          end
        end
        ocx_pkg::ST_OUT: begin
          ov_q    <= 1'b1;
          olast_q <= (cnt_q + CNT_W'(1) == n_i);
          owr_q   <= filled_q[cnt_q[IDX_W-1:0]];
          cnt_q   <= cnt_q + CNT_W'(1);
          if (cnt_q + CNT_W'(1) == n_i) begin
            state_q <= ocx_pkg::ST_IDLE;
          end
        end
        default: begin
          state_q <= ocx_pkg::ST_IDLE;
        end
      endcase

      if (cp_v_q) begin
        filled_q[cw_pos_q] <= 1'b1;
        if (p1_rd_q <= GW'(MAX_GENES)) begin
          used_q[p1_rd_q[CNT_W-1:0]] <= 1'b1;
        end
      end
      if (fill_we) begin
        filled_q[pos_q] <= 1'b1;
        pos_q           <= pos_nx;
        remain_q        <= remain_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.store) begin
      p1_mem[widx_i] <= cmd_i.gene1;
      p2_mem[widx_i] <= cmd_i.gene2;
    end
    if (ch_we) begin
      ch_mem[ch_wa] <= ch_wd;
    end
    p1_rd_q <= p1_mem[pos_q];
    p2_rd_q <= p2_mem[fr_q];
    ch_rd_q <= ch_mem[cnt_q[IDX_W-1:0]];
  end

  assign strobe_o = ov_q;
  assign last_o   = olast_q;
  assign gene_o   = owr_q ? ch_rd_q : '0;

endmodule

FILE: src/ordered_crossover_permutation.sv
// channel   signals                                         handshake
// -------   ---------------------------------------------   ---------------------------
// input     parent1/2_gene_i, cut_start/end_i, last_pair_i   start && !busy at the edge
// result    child_gene_o, child_last_o                      result_strobe_o, one cycle
// config    cfg_wdata_i (client_count)                      cfg_we_i, written at the edge
//
// Gene pairs are taken while busy is low and wait in a two-entry queue in front of the engine.
// A run holds the engine through the start step, a read of each copied gene
// through the parent one port, n reads plus a final check through the parent
// two port, then one child gene per cycle out of the child memory.
// busy is high only while the queue holds two items; the used-id map and the
// child fill flags clear in the cycle a run starts. Results cannot be held off.
module ordered_crossover_permutation #(
  parameter int unsigned MAX_GENES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [ocx_pkg::GENE_W-1:0]  parent1_gene_i,
  input  logic [ocx_pkg::GENE_W-1:0]  parent2_gene_i,
  input  logic [ocx_pkg::CUT_W-1:0]   cut_start_i,
  input  logic [ocx_pkg::CUT_W-1:0]   cut_end_i,
  input  logic                        last_pair_i,
  output logic                        result_strobe_o,
  output logic [ocx_pkg::GENE_W-1:0]  child_gene_o,
  output logic                        child_last_o,
  input  logic                        cfg_we_i,
  input  logic [ocx_pkg::COUNT_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W  = $clog2(MAX_GENES);
  localparam int unsigned CNT_W  = $clog2(MAX_GENES + 1);
  localparam int unsigned CMD_W  = $bits(ocx_pkg::ocx_cmd_t);
  localparam int unsigned DATA_W = CMD_W + 3 * IDX_W;

  logic [ocx_pkg::COUNT_W-1:0] count_q;
  logic [CNT_W-1:0]            n_eff;

  ocx_pkg::ocx_cmd_t f_cmd, b_cmd;
  logic [IDX_W-1:0]  f_widx, f_cs, f_ce, b_widx, b_cs, b_ce;
  logic [DATA_W-1:0] q_in, q_out;
  logic              accept, q_pop, q_empty, q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= ocx_pkg::CLIENT_COUNT_RST;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, anything above the store depth as the depth
  always_comb begin
    if (count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (count_q > ocx_pkg::COUNT_W'(MAX_GENES)) begin
      n_eff = CNT_W'(MAX_GENES);
    end else begin
      n_eff = count_q[CNT_W-1:0];
    end
  end

  assign busy   = q_full;
  assign accept = start && !busy;

  ocx_front #(
    .MAX_GENES (MAX_GENES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .n_i            (n_eff),
    .accept_i       (accept),
    .parent1_gene_i (parent1_gene_i),
    .parent2_gene_i (parent2_gene_i),
    .cut_start_i    (cut_start_i),
    .cut_end_i      (cut_end_i),
    .last_pair_i    (last_pair_i),
    .cmd_o          (f_cmd),
    .widx_o         (f_widx),
    .cs_o           (f_cs),
    .ce_o           (f_ce)
  );

  assign q_in = {f_cmd, f_widx, f_cs, f_ce};
  assign {b_cmd, b_widx, b_cs, b_ce} = q_out;

  ocx_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  ocx_back #(
    .MAX_GENES (MAX_GENES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .n_i      (n_eff),
    .avail_i  (!q_empty),
    .pop_o    (q_pop),
    .cmd_i    (b_cmd),
    .widx_i   (b_widx),
    .cs_i     (b_cs),
    .ce_i     (b_ce),
    .strobe_o (result_strobe_o),
    .gene_o   (child_gene_o),
    .last_o   (child_last_o)
  );

  // a run's genes leave in one unbroken burst
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !child_last_o) |=> result_strobe_o)
    else $error("child gene burst broken");

  // a run's final gene is never directly followed by another result
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && child_last_o) |=> !result_strobe_o)
    else $error("result right after final gene");

  // the engine only drains a non-empty queue
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
